@@ hdl/pcl_pkg.sv @@
// Package for the pseudocode lexer: scan modes, token kinds, byte codes,
// the keyword table and small character helpers.
// No dependencies.
`default_nettype none
package pcl_pkg;

   localparam int KEYWORD_MAX_DEF = 12;
   localparam int COUNT_BITS_DEF  = 24;
   localparam int KW_BYTES        = 16;
   localparam int KW_COUNT        = 62;
   localparam int FIFO_DEPTH      = 8;

   typedef enum logic [3:0] {
      M_IDLE, M_COMMENT, M_SLASH, M_LESS, M_GREATER, M_IDENT,
      M_NUMBER, M_NUMDOT, M_REAL, M_STRING, M_CHAR
   } scan_mode_type;

   // token kinds
   localparam logic [6:0] K_FALSE   = 7'd60;
   localparam logic [6:0] K_TRUE    = 7'd61;
   localparam logic [6:0] K_STRING  = 7'd62;
   localparam logic [6:0] K_CHAR    = 7'd63;
   localparam logic [6:0] K_INTEGER = 7'd64;
   localparam logic [6:0] K_REAL    = 7'd65;
   localparam logic [6:0] K_PLUS    = 7'd66;
   localparam logic [6:0] K_MINUS   = 7'd67;
   localparam logic [6:0] K_STAR    = 7'd68;
   localparam logic [6:0] K_DIV     = 7'd69;
   localparam logic [6:0] K_ASSIGN  = 7'd70;
   localparam logic [6:0] K_EQ      = 7'd71;
   localparam logic [6:0] K_NE      = 7'd72;
   localparam logic [6:0] K_LT      = 7'd73;
   localparam logic [6:0] K_LE      = 7'd74;
   localparam logic [6:0] K_GT      = 7'd75;
   localparam logic [6:0] K_GE      = 7'd76;
   localparam logic [6:0] K_CARET   = 7'd77;
   localparam logic [6:0] K_AMP     = 7'd78;
   localparam logic [6:0] K_COLON   = 7'd79;
   localparam logic [6:0] K_COMMA   = 7'd80;
   localparam logic [6:0] K_LPAREN  = 7'd81;
   localparam logic [6:0] K_RPAREN  = 7'd82;
   localparam logic [6:0] K_LBRACK  = 7'd83;
   localparam logic [6:0] K_RBRACK  = 7'd84;
   localparam logic [6:0] K_DOT     = 7'd85;
   localparam logic [6:0] K_EOF     = 7'd86;
   localparam logic [6:0] K_EOL     = 7'd87;
   localparam logic [6:0] K_IDENT   = 7'd88;
   localparam logic [6:0] K_ERROR   = 7'd89;

   // error codes
   localparam logic [2:0] E_NONE       = 3'd0;
   localparam logic [2:0] E_OPEN_STR   = 3'd1;
   localparam logic [2:0] E_OPEN_CHAR  = 3'd2;
   localparam logic [2:0] E_EMPTY_CHAR = 3'd3;
   localparam logic [2:0] E_MULTI_CHAR = 3'd4;
   localparam logic [2:0] E_UNEXPECTED = 3'd5;

   // byte codes
   localparam logic [7:0] CH_EOT    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LESS   = 8'h3C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GREAT  = 8'h3E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   // keyword text, right aligned, index equals token kind
   localparam logic [KW_BYTES*8-1:0] KW_TEXT [KW_COUNT] = '{
      "AND", "APPEND", "ARRAY", "BOOLEAN", "BYVAL", "BYREF", "CALL", "CASE",
      "CHAR", "CLASS", "CLOSEFILE", "CONSTANT", "DATE", "DECLARE", "DEFINE",
      "DIV", "ELSE", "ENDCASE", "ENDCLASS", "ENDFUNCTION", "ENDIF",
      "ENDPROCEDURE", "ENDTYPE", "ENDWHILE", "FOR", "FUNCTION", "GETRECORD",
      "IF", "INHERITS", "INPUT", "INTEGER", "MOD", "NEXT", "NEW", "NOT",
      "OPENFILE", "OR", "OTHERWISE", "OUTPUT", "PROCEDURE", "PRIVATE",
      "PUBLIC", "PUTRECORD", "RANDOM", "READ", "READFILE", "REAL", "REPEAT",
      "RETURN", "RETURNS", "SEEK", "STEP", "STRING", "SUPER", "THEN", "TYPE",
      "UNTIL", "WHILE", "WRITE", "WRITEFILE", "FALSE", "TRUE"};

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // exact match of a word against the keyword table; len is the word length
   function automatic logic [6:0] kw_lookup(input logic [KW_BYTES-1:0][7:0] wb,
                                            input logic [4:0] len);
      logic [6:0]            kind;
      logic                  hit;
      logic [4:0]            klen;
      logic [KW_BYTES*8-1:0] w;
      kind = K_IDENT;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         w    = KW_TEXT[i];
         klen = '0;
         for (int k = 0; k < KW_BYTES; k++) begin
            if (w[8*k +: 8] != 8'h00) begin
               klen = klen + 5'd1;
            end
         end
         hit = (klen == len);
         for (int j = 0; j < KW_BYTES; j++) begin
            if (5'(j) < klen) begin
               if (wb[j] != w[8*(int'(klen) - 1 - j) +: 8]) begin
                  hit = 1'b0;
               end
            end
         end
         if (hit) begin
            kind = 7'(i);
         end
      end
      return kind;
   endfunction

   // one-byte operators; bit 7 flags a match
   function automatic logic [7:0] single_op(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         8'h2B:   r = {1'b1, K_PLUS};
         8'h2D:   r = {1'b1, K_MINUS};
         8'h2A:   r = {1'b1, K_STAR};
         8'h3D:   r = {1'b1, K_EQ};
         8'h5E:   r = {1'b1, K_CARET};
         8'h26:   r = {1'b1, K_AMP};
         8'h3A:   r = {1'b1, K_COLON};
         8'h2C:   r = {1'b1, K_COMMA};
         8'h28:   r = {1'b1, K_LPAREN};
         8'h29:   r = {1'b1, K_RPAREN};
         8'h5B:   r = {1'b1, K_LBRACK};
         8'h5D:   r = {1'b1, K_RBRACK};
         8'h2E:   r = {1'b1, K_DOT};
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // mode entered when a byte starts a new token from idle
   function automatic scan_mode_type idle_mode(input logic [7:0] c);
      scan_mode_type m;
      if (c == CH_SLASH) m = M_SLASH;
      else if (is_alpha(c) || c == CH_UNDER) m = M_IDENT;
      else if (is_digit(c)) m = M_NUMBER;
      else if (c == CH_DQUOTE) m = M_STRING;
      else if (c == CH_SQUOTE) m = M_CHAR;
      else if (c == CH_LESS) m = M_LESS;
      else if (c == CH_GREAT) m = M_GREATER;
      else m = M_IDLE;
      return m;
   endfunction

endpackage
`default_nettype wire

@@ hdl/pseudocode_lexer_top.sv @@
// Streaming lexer for upper-case pseudocode: byte in, tokens out.
// Depends on pcl_pkg.
//
//  channel | ports                              | carries
//  req     | req_valid/req_ready/req_text_byte  | one source byte per item
//  rsp     | rsp_valid/rsp_ready/rsp_*          | one token per item
//
// A byte is scanned in the cycle it is accepted; its 0..3 tokens go into an
// 8-entry token queue, one token leaves per cycle while rsp_ready is high.
// One byte per cycle while each byte yields at most one token and rsp_ready
// stays high. req_ready drops while the queue has fewer than three free
// entries. Byte 0 ends a text and returns the scanner to its reset state.
// Synchronous reset clears the scanner and the queue.
`default_nettype none
module pseudocode_lexer_top #(
   parameter int KEYWORD_MAX = pcl_pkg::KEYWORD_MAX_DEF,
   parameter int COUNT_BITS  = pcl_pkg::COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_text_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [6:0]                 rsp_token_kind,
   output logic [COUNT_BITS-1:0]      rsp_start_offset,
   output logic [COUNT_BITS-1:0]      rsp_token_length,
   output logic [COUNT_BITS-1:0]      rsp_line_number,
   output logic [2:0]                 rsp_error_code,
   output logic                       rsp_last_of_run
);

   localparam int IDX_W = $clog2(KEYWORD_MAX);
   localparam int PTR_W = $clog2(pcl_pkg::FIFO_DEPTH);
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic [6:0]            kind;
      logic [COUNT_BITS-1:0] start;
      logic [COUNT_BITS-1:0] len;
      logic [COUNT_BITS-1:0] line;
      logic [2:0]            err;
      logic                  last;
   } token_type;

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                     input logic [1:0] b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {{(COUNT_BITS-1){1'b0}}, b};
      return s[COUNT_BITS] ? CMAX : s[COUNT_BITS-1:0];
   endfunction

   function automatic token_type mk(input logic [6:0] kind,
                                    input logic [COUNT_BITS-1:0] start,
                                    input logic [COUNT_BITS-1:0] len,
                                    input logic [COUNT_BITS-1:0] line,
                                    input logic [2:0] err);
      token_type t;
      t.kind  = kind;
      t.start = start;
      t.len   = len;
      t.line  = line;
      t.err   = err;
      t.last  = 1'b0;
      return t;
   endfunction

   pcl_pkg::scan_mode_type mode_ff, mode_in;
   logic [COUNT_BITS-1:0]  tstart_ff, tstart_in;
   logic [COUNT_BITS-1:0]  pos_ff, pos_in;
   logic [COUNT_BITS-1:0]  line_ff, line_in;
   logic [COUNT_BITS-1:0]  tlen_ff, tlen_in;
   logic [7:0]             wbuf_ff [KEYWORD_MAX];
   logic                   wb_we;
   logic [IDX_W-1:0]       wb_idx;

   token_type              fifo_ff [pcl_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]         count_ff;

   token_type              tok [3];
   logic [1:0]             tok_n;
   logic                   accept, pop;
   logic [7:0]             c;
   logic                   word_c;
   logic                   run_idle;
   logic [7:0]             op;
   logic [pcl_pkg::KW_BYTES-1:0][7:0] kw_bytes;
   logic [6:0]             word_kind;
   logic [COUNT_BITS-1:0]  len1;

   assign c         = req_text_byte;
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = count_ff <= (PTR_W+1)'(pcl_pkg::FIFO_DEPTH - 3);
   assign rsp_valid = count_ff != '0;
   assign word_c    = pcl_pkg::is_alpha(c) || pcl_pkg::is_digit(c) || c == pcl_pkg::CH_UNDER;
   assign op        = pcl_pkg::single_op(c);
   assign len1      = sat_add(tlen_ff, 2'd1);

   always_comb begin
      for (int i = 0; i < pcl_pkg::KW_BYTES; i++) begin
         kw_bytes[i] = (i < KEYWORD_MAX) ? wbuf_ff[i % KEYWORD_MAX] : 8'h00;
      end
      if (tlen_ff > COUNT_BITS'(KEYWORD_MAX)) begin
         word_kind = pcl_pkg::K_IDENT;
      end else begin
         word_kind = pcl_pkg::kw_lookup(kw_bytes, tlen_ff[4:0]);
      end
   end

   // next scan mode
   always_comb begin
      mode_in = pcl_pkg::idle_mode(c);
      case (mode_ff)
         pcl_pkg::M_COMMENT: if (c != pcl_pkg::CH_NL && c != pcl_pkg::CH_EOT) begin
            mode_in = pcl_pkg::M_COMMENT;
         end
         pcl_pkg::M_SLASH: if (c == pcl_pkg::CH_SLASH) begin
            mode_in = pcl_pkg::M_COMMENT;
         end
         pcl_pkg::M_LESS: if (c == pcl_pkg::CH_MINUS || c == pcl_pkg::CH_EQUAL ||
                              c == pcl_pkg::CH_GREAT) begin
            mode_in = pcl_pkg::M_IDLE;
         end
         pcl_pkg::M_GREATER: if (c == pcl_pkg::CH_EQUAL) begin
            mode_in = pcl_pkg::M_IDLE;
         end
         pcl_pkg::M_IDENT: if (word_c) begin
            mode_in = pcl_pkg::M_IDENT;
         end
         pcl_pkg::M_NUMBER: begin
            if (pcl_pkg::is_digit(c)) mode_in = pcl_pkg::M_NUMBER;
            else if (c == pcl_pkg::CH_DOT) mode_in = pcl_pkg::M_NUMDOT;
         end
         pcl_pkg::M_NUMDOT, pcl_pkg::M_REAL: if (pcl_pkg::is_digit(c)) begin
            mode_in = pcl_pkg::M_REAL;
         end
         pcl_pkg::M_STRING: begin
            if (c == pcl_pkg::CH_EOT || c == pcl_pkg::CH_DQUOTE) mode_in = pcl_pkg::M_IDLE;
            else mode_in = pcl_pkg::M_STRING;
         end
         pcl_pkg::M_CHAR: begin
            if (c == pcl_pkg::CH_EOT || c == pcl_pkg::CH_SQUOTE) mode_in = pcl_pkg::M_IDLE;
            else mode_in = pcl_pkg::M_CHAR;
         end
         default: ;
      endcase
      if (c == pcl_pkg::CH_EOT) mode_in = pcl_pkg::M_IDLE;
   end

   // tokens and counters for the current byte
   always_comb begin
      for (int k = 0; k < 3; k++) tok[k] = mk(7'd0, '0, '0, '0, pcl_pkg::E_NONE);
      tok_n     = 2'd0;
      tstart_in = tstart_ff;
      tlen_in   = tlen_ff;
      line_in   = line_ff;
      wb_we     = 1'b0;
      wb_idx    = tlen_ff[IDX_W-1:0];
      run_idle  = 1'b1;
      case (mode_ff)
         pcl_pkg::M_COMMENT: begin
            if (c != pcl_pkg::CH_NL && c != pcl_pkg::CH_EOT) run_idle = 1'b0;
         end
         pcl_pkg::M_SLASH: begin
            if (c == pcl_pkg::CH_SLASH) run_idle = 1'b0;
            else begin
               tok[0] = mk(pcl_pkg::K_DIV, tstart_ff, COUNT_BITS'(1), line_ff,
                           pcl_pkg::E_NONE);
               tok_n = 2'd1;
            end
         end
         pcl_pkg::M_LESS: begin
            run_idle = 1'b0;
            tok_n    = 2'd1;
            if (c == pcl_pkg::CH_MINUS)
               tok[0] = mk(pcl_pkg::K_ASSIGN, tstart_ff, COUNT_BITS'(2), line_ff,
                           pcl_pkg::E_NONE);
            else if (c == pcl_pkg::CH_EQUAL)
               tok[0] = mk(pcl_pkg::K_LE, tstart_ff, COUNT_BITS'(2), line_ff,
                           pcl_pkg::E_NONE);
            else if (c == pcl_pkg::CH_GREAT)
               tok[0] = mk(pcl_pkg::K_NE, tstart_ff, COUNT_BITS'(2), line_ff,
                           pcl_pkg::E_NONE);
            else begin
               run_idle = 1'b1;
               tok[0] = mk(pcl_pkg::K_LT, tstart_ff, COUNT_BITS'(1), line_ff,
                           pcl_pkg::E_NONE);
            end
         end
         pcl_pkg::M_GREATER: begin
            tok_n = 2'd1;
            if (c == pcl_pkg::CH_EQUAL) begin
               run_idle = 1'b0;
               tok[0] = mk(pcl_pkg::K_GE, tstart_ff, COUNT_BITS'(2), line_ff,
                           pcl_pkg::E_NONE);
            end else begin
               tok[0] = mk(pcl_pkg::K_GT, tstart_ff, COUNT_BITS'(1), line_ff,
                           pcl_pkg::E_NONE);
            end
         end
         pcl_pkg::M_IDENT: begin
            if (word_c) begin
               run_idle = 1'b0;
               wb_we    = tlen_ff < COUNT_BITS'(KEYWORD_MAX);
               tlen_in  = len1;
            end else begin
               tok[0] = mk(word_kind, tstart_ff, tlen_ff, line_ff, pcl_pkg::E_NONE);
               tok_n  = 2'd1;
            end
         end
         pcl_pkg::M_NUMBER: begin
            if (pcl_pkg::is_digit(c)) begin
               run_idle = 1'b0;
               tlen_in  = len1;
            end else if (c == pcl_pkg::CH_DOT) begin
               run_idle = 1'b0;
            end else begin
               tok[0] = mk(pcl_pkg::K_INTEGER, tstart_ff, tlen_ff, line_ff,
                           pcl_pkg::E_NONE);
               tok_n  = 2'd1;
            end
         end
         pcl_pkg::M_NUMDOT: begin
            if (pcl_pkg::is_digit(c)) begin
               run_idle = 1'b0;
               tlen_in  = sat_add(tlen_ff, 2'd2);
            end else begin
               // the dot was not a decimal point: integer, then a dot token
               tok[0] = mk(pcl_pkg::K_INTEGER, tstart_ff, tlen_ff, line_ff,
                           pcl_pkg::E_NONE);
               tok[1] = mk(pcl_pkg::K_DOT, sat_add(tstart_ff, 2'd0) == CMAX ? CMAX :
                           (({1'b0, tstart_ff} + {1'b0, tlen_ff}) > {1'b0, CMAX} ? CMAX :
                            tstart_ff + tlen_ff),
                           COUNT_BITS'(1), line_ff, pcl_pkg::E_NONE);
               tok_n  = 2'd2;
            end
         end
         pcl_pkg::M_REAL: begin
            if (pcl_pkg::is_digit(c)) begin
               run_idle = 1'b0;
               tlen_in  = len1;
            end else begin
               tok[0] = mk(pcl_pkg::K_REAL, tstart_ff, tlen_ff, line_ff,
                           pcl_pkg::E_NONE);
               tok_n  = 2'd1;
            end
         end
         pcl_pkg::M_STRING: begin
            if (c == pcl_pkg::CH_EOT) begin
               tok[0] = mk(pcl_pkg::K_ERROR, tstart_ff, tlen_ff, line_ff,
                           pcl_pkg::E_OPEN_STR);
               tok_n  = 2'd1;
            end else begin
               run_idle = 1'b0;
               tlen_in  = len1;
               if (c == pcl_pkg::CH_NL) line_in = sat_add(line_ff, 2'd1);
               if (c == pcl_pkg::CH_DQUOTE) begin
                  tok[0] = mk(pcl_pkg::K_STRING, tstart_ff, len1, line_ff,
                              pcl_pkg::E_NONE);
                  tok_n  = 2'd1;
               end
            end
         end
         pcl_pkg::M_CHAR: begin
            if (c == pcl_pkg::CH_EOT) begin
               tok[0] = mk(pcl_pkg::K_ERROR, tstart_ff, tlen_ff, line_ff,
                           pcl_pkg::E_OPEN_CHAR);
               tok_n  = 2'd1;
            end else begin
               run_idle = 1'b0;
               tlen_in  = len1;
               if (c == pcl_pkg::CH_NL) line_in = sat_add(line_ff, 2'd1);
               if (c == pcl_pkg::CH_SQUOTE) begin
                  tok_n = 2'd1;
                  if (len1 == COUNT_BITS'(2))
                     tok[0] = mk(pcl_pkg::K_ERROR, tstart_ff, len1, line_ff,
                                 pcl_pkg::E_EMPTY_CHAR);
                  else if (len1 > COUNT_BITS'(4))
                     tok[0] = mk(pcl_pkg::K_ERROR, tstart_ff, len1, line_ff,
                                 pcl_pkg::E_MULTI_CHAR);
                  else
                     tok[0] = mk(pcl_pkg::K_CHAR, tstart_ff, len1, line_ff,
                                 pcl_pkg::E_NONE);
               end
            end
         end
         default: ;
      endcase

      if (run_idle) begin
         tstart_in = pos_ff;
         tlen_in   = COUNT_BITS'(1);
         if (c == pcl_pkg::CH_EOT) begin
            tok[tok_n] = mk(pcl_pkg::K_EOF, pos_ff, '0, line_ff, pcl_pkg::E_NONE);
            tok_n = tok_n + 2'd1;
         end else if (c == pcl_pkg::CH_NL) begin
            line_in    = sat_add(line_ff, 2'd1);
            tok[tok_n] = mk(pcl_pkg::K_EOL, pos_ff, COUNT_BITS'(1), line_in,
                            pcl_pkg::E_NONE);
            tok_n = tok_n + 2'd1;
         end else if (pcl_pkg::is_alpha(c) || c == pcl_pkg::CH_UNDER) begin
            wb_we  = 1'b1;
            wb_idx = '0;
         end else if (c == pcl_pkg::CH_SPACE || c == pcl_pkg::CH_CR ||
                      c == pcl_pkg::CH_TAB || pcl_pkg::idle_mode(c) != pcl_pkg::M_IDLE) begin
            // blank, or first byte of a longer token
         end else if (op[7]) begin
            tok[tok_n] = mk(op[6:0], pos_ff, COUNT_BITS'(1), line_ff, pcl_pkg::E_NONE);
            tok_n = tok_n + 2'd1;
         end else begin
            tok[tok_n] = mk(pcl_pkg::K_ERROR, pos_ff, COUNT_BITS'(1), line_ff,
                            pcl_pkg::E_UNEXPECTED);
            tok_n = tok_n + 2'd1;
         end
      end

      if (tok_n != 2'd0) tok[tok_n - 2'd1].last = 1'b1;

      if (c == pcl_pkg::CH_EOT) begin
         tstart_in = '0;
         pos_in    = '0;
         line_in   = COUNT_BITS'(1);
         tlen_in   = '0;
      end else begin
         pos_in    = sat_add(pos_ff, 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= pcl_pkg::M_IDLE;
         tstart_ff <= '0;
         pos_ff    <= '0;
         line_ff   <= COUNT_BITS'(1);
         tlen_ff   <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         tstart_ff <= tstart_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         tlen_ff   <= tlen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && wb_we) wbuf_ff[wb_idx] <= c;
   end

   // token queue
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < 3; k++) begin
            if (2'(k) < tok_n) fifo_ff[wr_ptr_ff + PTR_W'(k)] <= tok[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) wr_ptr_ff <= wr_ptr_ff + PTR_W'(tok_n);
         if (pop) rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_ff + (accept ? (PTR_W+1)'(tok_n) : '0) - (PTR_W+1)'(pop);
      end
   end

   assign rsp_token_kind   = fifo_ff[rd_ptr_ff].kind;
   assign rsp_start_offset = fifo_ff[rd_ptr_ff].start;
   assign rsp_token_length = fifo_ff[rd_ptr_ff].len;
   assign rsp_line_number  = fifo_ff[rd_ptr_ff].line;
   assign rsp_error_code   = fifo_ff[rd_ptr_ff].err;
   assign rsp_last_of_run  = fifo_ff[rd_ptr_ff].last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W+1)'(pcl_pkg::FIFO_DEPTH))
      else $error("token queue overflow");

   a_eot_emits: assert property (@(posedge clock) disable iff (reset)
      accept && c == pcl_pkg::CH_EOT |-> tok_n != 2'd0)
      else $error("end of text gave no token");

   a_eot_restart: assert property (@(posedge clock) disable iff (reset)
      accept && c == pcl_pkg::CH_EOT |=> pos_ff == '0 && line_ff == COUNT_BITS'(1))
      else $error("scanner not restarted after end of text");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line counter at zero");

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for pseudocode_lexer_top: streams source text bytes, predicts the
// token stream with an in-bench scanner model and checks every token.
// Depends on pcl_pkg and the lexer RTL.
`default_nettype none
module tb_top;

   localparam int CW = 24;
   localparam logic [CW-1:0] CMAX = {CW{1'b1}};

   typedef struct packed {
      logic [6:0]    kind;
      logic [CW-1:0] offs;
      logic [CW-1:0] len;
      logic [CW-1:0] line;
      logic [2:0]    err;
      logic          last;
   } token_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [7:0]    req_text_byte = 8'h00;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [6:0]    rsp_token_kind;
   logic [CW-1:0] rsp_start_offset, rsp_token_length, rsp_line_number;
   logic [2:0]    rsp_error_code;
   logic          rsp_last_of_run;

   pseudocode_lexer_top dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // scanner model state
   pcl_pkg::scan_mode_type lx_mode;
   logic [CW-1:0] lx_start, lx_pos, lx_line, lx_len;
   logic [7:0]    lx_word [pcl_pkg::KEYWORD_MAX_DEF];
   token_type     tok_q [$];
   token_type     run_toks [$];

   int  mismatches = 0;
   int  bytes_sent = 0;
   int  tokens_seen = 0;
   bit  quiet = 1'b0;
   int  hold_cycles = 0;

   string kw_names [62] = '{
      "AND", "APPEND", "ARRAY", "BOOLEAN", "BYVAL", "BYREF", "CALL", "CASE",
      "CHAR", "CLASS", "CLOSEFILE", "CONSTANT", "DATE", "DECLARE", "DEFINE",
      "DIV", "ELSE", "ENDCASE", "ENDCLASS", "ENDFUNCTION", "ENDIF",
      "ENDPROCEDURE", "ENDTYPE", "ENDWHILE", "FOR", "FUNCTION", "GETRECORD",
      "IF", "INHERITS", "INPUT", "INTEGER", "MOD", "NEXT", "NEW", "NOT",
      "OPENFILE", "OR", "OTHERWISE", "OUTPUT", "PROCEDURE", "PRIVATE",
      "PUBLIC", "PUTRECORD", "RANDOM", "READ", "READFILE", "REAL", "REPEAT",
      "RETURN", "RETURNS", "SEEK", "STEP", "STRING", "SUPER", "THEN", "TYPE",
      "UNTIL", "WHILE", "WRITE", "WRITEFILE", "FALSE", "TRUE"};

   function automatic logic [CW-1:0] sat_inc(logic [CW-1:0] a, int b);
      logic [CW:0] s;
      s = {1'b0, a} + (CW+1)'(b);
      return s[CW] ? CMAX : s[CW-1:0];
   endfunction

   function automatic bit alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function void push_tok(logic [6:0] k, logic [CW-1:0] s, logic [CW-1:0] n,
                          logic [2:0] e);
      token_type t;
      t = '{k, s, n, lx_line, e, 1'b0};
      run_toks.push_back(t);
   endfunction

   function void scanner_clear();
      lx_mode = pcl_pkg::M_IDLE;
      lx_start = '0;
      lx_pos = '0;
      lx_line = 1;
      lx_len = '0;
   endfunction

   function logic [6:0] word_class();
      string w;
      w = "";
      if (lx_len > pcl_pkg::KEYWORD_MAX_DEF) return pcl_pkg::K_IDENT;
      for (int i = 0; i < lx_len; i++) w = {w, string'(lx_word[i])};
      for (int i = 0; i < 62; i++)
         if (w == kw_names[i]) return 7'(i);
      return pcl_pkg::K_IDENT;
   endfunction

   function void start_token(logic [7:0] c);
      lx_start = lx_pos;
      lx_len = 1;
      lx_mode = pcl_pkg::M_IDLE;
      case (c)
         pcl_pkg::CH_EOT: push_tok(pcl_pkg::K_EOF, lx_pos, '0, pcl_pkg::E_NONE);
         pcl_pkg::CH_SPACE, pcl_pkg::CH_CR, pcl_pkg::CH_TAB: ;
         pcl_pkg::CH_SLASH: lx_mode = pcl_pkg::M_SLASH;
         pcl_pkg::CH_NL: begin
            lx_line = sat_inc(lx_line, 1);
            push_tok(pcl_pkg::K_EOL, lx_start, 1, pcl_pkg::E_NONE);
         end
         pcl_pkg::CH_DQUOTE: lx_mode = pcl_pkg::M_STRING;
         pcl_pkg::CH_SQUOTE: lx_mode = pcl_pkg::M_CHAR;
         pcl_pkg::CH_LESS: lx_mode = pcl_pkg::M_LESS;
         pcl_pkg::CH_GREAT: lx_mode = pcl_pkg::M_GREATER;
         "+": push_tok(pcl_pkg::K_PLUS, lx_start, 1, pcl_pkg::E_NONE);
         "-": push_tok(pcl_pkg::K_MINUS, lx_start, 1, pcl_pkg::E_NONE);
         "*": push_tok(pcl_pkg::K_STAR, lx_start, 1, pcl_pkg::E_NONE);
         "=": push_tok(pcl_pkg::K_EQ, lx_start, 1, pcl_pkg::E_NONE);
         "^": push_tok(pcl_pkg::K_CARET, lx_start, 1, pcl_pkg::E_NONE);
         "&": push_tok(pcl_pkg::K_AMP, lx_start, 1, pcl_pkg::E_NONE);
         ":": push_tok(pcl_pkg::K_COLON, lx_start, 1, pcl_pkg::E_NONE);
         ",": push_tok(pcl_pkg::K_COMMA, lx_start, 1, pcl_pkg::E_NONE);
         "(": push_tok(pcl_pkg::K_LPAREN, lx_start, 1, pcl_pkg::E_NONE);
         ")": push_tok(pcl_pkg::K_RPAREN, lx_start, 1, pcl_pkg::E_NONE);
         "[": push_tok(pcl_pkg::K_LBRACK, lx_start, 1, pcl_pkg::E_NONE);
         "]": push_tok(pcl_pkg::K_RBRACK, lx_start, 1, pcl_pkg::E_NONE);
         ".": push_tok(pcl_pkg::K_DOT, lx_start, 1, pcl_pkg::E_NONE);
         default: begin
            if (alpha(c) || c == pcl_pkg::CH_UNDER) begin
               lx_word[0] = c;
               lx_mode = pcl_pkg::M_IDENT;
            end else if (digit(c)) begin
               lx_mode = pcl_pkg::M_NUMBER;
            end else begin
               push_tok(pcl_pkg::K_ERROR, lx_start, 1, pcl_pkg::E_UNEXPECTED);
            end
         end
      endcase
   endfunction

   // returns 1 when the byte also has to be scanned from idle
   function bit continue_token(logic [7:0] c);
      case (lx_mode)
         pcl_pkg::M_COMMENT: return c == pcl_pkg::CH_NL || c == pcl_pkg::CH_EOT;
         pcl_pkg::M_SLASH: begin
            if (c == pcl_pkg::CH_SLASH) begin
               lx_mode = pcl_pkg::M_COMMENT;
               return 0;
            end
            push_tok(pcl_pkg::K_DIV, lx_start, 1, pcl_pkg::E_NONE);
         end
         pcl_pkg::M_LESS: begin
            if (c == pcl_pkg::CH_MINUS || c == pcl_pkg::CH_EQUAL ||
                c == pcl_pkg::CH_GREAT) begin
               push_tok(c == pcl_pkg::CH_MINUS ? pcl_pkg::K_ASSIGN :
                        (c == pcl_pkg::CH_EQUAL ? pcl_pkg::K_LE : pcl_pkg::K_NE),
                        lx_start, 2, pcl_pkg::E_NONE);
               lx_mode = pcl_pkg::M_IDLE;
               return 0;
            end
            push_tok(pcl_pkg::K_LT, lx_start, 1, pcl_pkg::E_NONE);
         end
         pcl_pkg::M_GREATER: begin
            if (c == pcl_pkg::CH_EQUAL) begin
               push_tok(pcl_pkg::K_GE, lx_start, 2, pcl_pkg::E_NONE);
               lx_mode = pcl_pkg::M_IDLE;
               return 0;
            end
            push_tok(pcl_pkg::K_GT, lx_start, 1, pcl_pkg::E_NONE);
         end
         pcl_pkg::M_IDENT: begin
            if (alpha(c) || digit(c) || c == pcl_pkg::CH_UNDER) begin
               if (lx_len < pcl_pkg::KEYWORD_MAX_DEF) lx_word[lx_len] = c;
               lx_len = sat_inc(lx_len, 1);
               return 0;
            end
            push_tok(word_class(), lx_start, lx_len, pcl_pkg::E_NONE);
         end
         pcl_pkg::M_NUMBER: begin
            if (digit(c)) begin
               lx_len = sat_inc(lx_len, 1);
               return 0;
            end
            if (c == pcl_pkg::CH_DOT) begin
               lx_mode = pcl_pkg::M_NUMDOT;
               return 0;
            end
            push_tok(pcl_pkg::K_INTEGER, lx_start, lx_len, pcl_pkg::E_NONE);
         end
         pcl_pkg::M_NUMDOT: begin
            if (digit(c)) begin
               lx_len = sat_inc(lx_len, 2);
               lx_mode = pcl_pkg::M_REAL;
               return 0;
            end
            push_tok(pcl_pkg::K_INTEGER, lx_start, lx_len, pcl_pkg::E_NONE);
            push_tok(pcl_pkg::K_DOT, sat_inc(lx_start, int'(lx_len)), 1, pcl_pkg::E_NONE);
         end
         pcl_pkg::M_REAL: begin
            if (digit(c)) begin
               lx_len = sat_inc(lx_len, 1);
               return 0;
            end
            push_tok(pcl_pkg::K_REAL, lx_start, lx_len, pcl_pkg::E_NONE);
         end
         pcl_pkg::M_STRING, pcl_pkg::M_CHAR: begin
            if (c == pcl_pkg::CH_EOT) begin
               push_tok(pcl_pkg::K_ERROR, lx_start, lx_len,
                        lx_mode == pcl_pkg::M_STRING ? pcl_pkg::E_OPEN_STR :
                                                       pcl_pkg::E_OPEN_CHAR);
               return 1;
            end
            if (c == pcl_pkg::CH_NL) lx_line = sat_inc(lx_line, 1);
            lx_len = sat_inc(lx_len, 1);
            if (lx_mode == pcl_pkg::M_STRING && c == pcl_pkg::CH_DQUOTE) begin
               push_tok(pcl_pkg::K_STRING, lx_start, lx_len, pcl_pkg::E_NONE);
               lx_mode = pcl_pkg::M_IDLE;
            end else if (lx_mode == pcl_pkg::M_CHAR && c == pcl_pkg::CH_SQUOTE) begin
               if (lx_len == 2)
                  push_tok(pcl_pkg::K_ERROR, lx_start, lx_len, pcl_pkg::E_EMPTY_CHAR);
               else if (lx_len > 4)
                  push_tok(pcl_pkg::K_ERROR, lx_start, lx_len, pcl_pkg::E_MULTI_CHAR);
               else
                  push_tok(pcl_pkg::K_CHAR, lx_start, lx_len, pcl_pkg::E_NONE);
               lx_mode = pcl_pkg::M_IDLE;
            end
            return 0;
         end
         default: ;
      endcase
      return 1;
   endfunction

   function void predict_byte(logic [7:0] c);
      run_toks.delete();
      if (continue_token(c)) start_token(c);
      if (c == pcl_pkg::CH_EOT) scanner_clear();
      else lx_pos = sat_inc(lx_pos, 1);
      if (run_toks.size() > 0) run_toks[run_toks.size() - 1].last = 1'b1;
      foreach (run_toks[i]) tok_q.push_back(run_toks[i]);
   endfunction

   // valid drops only for an idle burst; otherwise the next byte follows directly
   task automatic send_byte(logic [7:0] c);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= c;
      do @(posedge clock); while (!req_ready);
      predict_byte(c);
      bytes_sent++;
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet ? 1'b1 : ($urandom_range(0, 4) != 0);
      end
   end

   always @(posedge clock) begin
      token_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_token_kind, rsp_start_offset, rsp_token_length, rsp_line_number,
                 rsp_error_code, rsp_last_of_run};
         tokens_seen++;
         if (tok_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected token %p", got);
         end else begin
            want = tok_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("token mismatch: exp %p got %p", want, got);
            end
         end
      end
   end

   task automatic test_keywords();
      send_text("IF OR NEW ENDPROCEDURE FALSE TRUE ");
      repeat (6) send_text({kw_names[$urandom_range(0, 61)], " "});
      send_text("IFX OR1 NEWS N ENDPROCEDURES if _a9 ABCDEFGHIJKLMNOP\n");
      send_byte(pcl_pkg::CH_EOT);
   endtask

   task automatic test_operators();
      send_text("a<-1+2-3*4/5=6<>7<8<=9>0>=1^2&:,()[].x<y>z/");
      send_text("\n12.5 3. 7.x 42\t\r// note <- \n//x");
      send_byte(pcl_pkg::CH_EOT);
   endtask

   task automatic test_literals();
      send_text("\"hi\nthere\" 'a' '' 'ab' 'abc' 'abcd' '\n' \"open");
      send_byte(pcl_pkg::CH_EOT);
      send_text("'x");
      send_byte(pcl_pkg::CH_EOT);
      send_text("9.");
      send_byte(pcl_pkg::CH_EOT);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(8'h01);
      send_byte(pcl_pkg::CH_EOT);
   endtask

   task automatic test_backpressure();
      hold_cycles = 60;
      repeat (12) send_text("1.. ");
   endtask

   function automatic string random_word();
      string s;
      int n;
      s = "";
      n = $urandom_range(1, 14);
      for (int i = 0; i < n; i++)
         case ($urandom_range(0, 3))
            0: s = {s, string'(8'($urandom_range("a", "z")))};
            1: s = {s, string'(8'($urandom_range("0", "9")))};
            2: s = {s, "_"};
            default: s = {s, string'(8'($urandom_range("A", "Z")))};
         endcase
      return s;
   endfunction

   task automatic test_random_text();
      string frag;
      while (bytes_sent < 350) begin
         case ($urandom_range(0, 11))
            0: frag = kw_names[$urandom_range(0, 61)];
            1: frag = random_word();
            2: frag = $sformatf("%0d", $urandom_range(0, 99999));
            3: frag = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
            4: frag = $sformatf("\"%s\"", random_word());
            5: frag = {"'", random_word().substr(0, $urandom_range(0, 3)), "'"};
            6: frag = "<-";
            7: frag = "// c\n";
            8: frag = "\n";
            9: frag = string'(8'($urandom_range(0, 255)));
            default: frag = " ";
         endcase
         if (frag.len() == 0) frag = " ";
         send_text(frag);
         if ($urandom_range(0, 30) == 0) send_byte(pcl_pkg::CH_EOT);
      end
      send_byte(pcl_pkg::CH_EOT);
   endtask

   task automatic test_no_idle();
      quiet = 1'b1;
      repeat (3) send_text("IF x<=2.5 THEN 'c'\n");
      send_byte(pcl_pkg::CH_EOT);
   endtask

   initial begin
      scanner_clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_keywords();
      test_operators();
      test_literals();
      test_backpressure();
      test_random_text();
      test_no_idle();
      req_valid <= 1'b0;
      while (tok_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d bytes, checked %0d tokens: keywords, operators, literals,",
               bytes_sent, tokens_seen);
      $display("errors, end of text, output hold-off and random text");
      if (mismatches == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      #3000000;
      $display("tb_top NOT OK");
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/pcl_pkg.sv
hdl/pseudocode_lexer_top.sv
bench/tb_top.sv
